// ===== sv/wsm_pkg.sv =====
// Shared types and constants of the wildcard byte signature matcher.
`default_nettype none

package wsm_pkg;

    localparam int MAX_PATTERN_LEN_DEF = 16;
    localparam int OFFSET_BITS_DEF     = 32;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 5;
    localparam int MASK_W       = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int RESULT_OFF_W = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_CARE_MASK    = 2'd2,
        REG_PATTERN_LEN  = 2'd3
    } cfg_reg_t;

    // per-cycle control handed to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic                    found;
        logic [RESULT_OFF_W-1:0] match_offset;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/wsm_channels.sv =====
// Valid/ready channel interfaces for the byte stream and the search results.
`default_nettype none

interface wsm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsm_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

// ===== sv/wsm_cell.sv =====
// One byte cell of the search window: holds a byte, passes it on, compares it.
`default_nettype none

module wsm_cell
    import wsm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic [BYTE_W-1:0] pat_byte,
    input  wire logic              care,
    output logic      [BYTE_W-1:0] byte_out,
    output logic                   hit
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // compare the byte this cell takes in on a shift
    assign hit      = !care || (byte_in == pat_byte);
    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// ===== sv/wsm_result_fifo.sv =====
// Two-slot result queue between the window logic and the result channel.
`default_nettype none

module wsm_result_fifo
    import wsm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t     slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign pop = (count_reg != 2'd0) && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== sv/wildcard_byte_signature_match.sv =====
// Top level of the wildcard byte signature matcher.
`default_nettype none

// Streams a memory region one byte per item and reports the start offset of the
// first match of the configured byte pattern (up to MAX_PATTERN_LEN bytes,
// wildcard where the care mask bit is clear). The block takes one byte
// every cycle: the window is a row of MAX_PATTERN_LEN byte cells that all
// compare in parallel against the incoming byte stream, so the compare is
// combinational. A result is registered in the two-slot result queue as its
// byte is accepted; the queue keeps bytes flowing while a result waits, and
// the byte channel stalls only when both slots are full. Each region gives
// exactly one result: found with the start offset, or not-found with offset 0
// on the region's last byte. After a match the rest of the region is skipped.
// The user must write registers through the plain write port while no region
// item is in flight; the block does not enforce this. They are not read back.

module wildcard_byte_signature_match
    import wsm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    wsm_byte_if.sink                    bytes,
    wsm_result_if.source                results,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int OFF_EXT_W = (OFFSET_BITS > RESULT_OFF_W) ? OFFSET_BITS : RESULT_OFF_W;

    // configuration registers
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [MASK_W-1:0]     care_mask_reg;
    logic [LEN_W-1:0]      pattern_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '0;
            pattern_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_CARE_MASK:    care_mask_reg    <= cfg_data[MASK_W-1:0];
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // length in use, clamped to the window size
    logic [LEN_W-1:0]        eff_len;
    logic [2*CFG_DATA_W-1:0] pattern_all;

    assign eff_len = (pattern_len_reg > LEN_W'(MAX_PATTERN_LEN)) ?
                     LEN_W'(MAX_PATTERN_LEN) : pattern_len_reg;
    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // region state
    logic [OFFSET_BITS-1:0] byte_count_reg;
    logic [OFFSET_BITS-1:0] byte_count_next;
    logic                   match_done_reg;
    logic                   match_done_next;

    logic                   accept;
    logic                   step;
    logic                   region_end;
    logic                   counted;
    logic [OFFSET_BITS-1:0] count_inc;
    logic [OFFSET_BITS-1:0] len_ext;
    logic                   match_all;
    logic                   hit_now;
    logic                   push;
    logic                   fifo_full;
    result_t                push_data;
    result_t                head_data;
    logic [OFF_EXT_W-1:0]   off_ext;
    cell_ctrl_t             cell_ctrl;

    assign accept     = bytes.valid && bytes.ready;
    assign step       = accept && !match_done_reg;
    assign region_end = accept && bytes.last_byte;

    assign cell_ctrl.shift = step;
    assign cell_ctrl.clear = region_end;

    // window: cell 0 holds the oldest byte, the top cell takes the new byte
    logic [BYTE_W-1:0]          window [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] hits;

    for (genvar i = 0; i < MAX_PATTERN_LEN; i++)
    begin : g_cell
        localparam logic [LEN_W-1:0] DIST = LEN_W'(MAX_PATTERN_LEN - 1 - i);

        logic [BYTE_W-1:0] byte_in;
        logic              active;
        logic [LEN_W-1:0]  pat_idx;
        logic [BYTE_W-1:0] pat_byte;
        logic              care;

        if (i == MAX_PATTERN_LEN - 1)
        begin : g_head
            assign byte_in = bytes.data_byte;
        end
        else
        begin : g_body
            assign byte_in = window[i+1];
        end

        // cells within the pattern length line up with pattern byte len-1-dist
        assign active   = DIST < eff_len;
        assign pat_idx  = eff_len - LEN_W'(1) - DIST;
        assign pat_byte = pattern_all[BYTE_W*pat_idx[3:0] +: BYTE_W];
        assign care     = active && care_mask_reg[pat_idx[3:0]];

        wsm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .byte_in  (byte_in),
            .pat_byte (pat_byte),
            .care     (care),
            .byte_out (window[i]),
            .hit      (hits[i])
        );
    end

    assign match_all = &hits;

    // counter saturates; a saturated counter tests no more start positions
    assign counted   = (byte_count_reg != {OFFSET_BITS{1'b1}});
    assign count_inc = byte_count_reg + OFFSET_BITS'(1);
    assign len_ext   = OFFSET_BITS'(eff_len);
    assign hit_now   = step && counted && (count_inc >= len_ext) && match_all;
    assign push      = hit_now || (step && bytes.last_byte);

    assign off_ext = OFF_EXT_W'(count_inc - len_ext);

    always_comb
    begin
        push_data.found        = hit_now;
        push_data.match_offset = '0;
        if (hit_now && (eff_len != '0))
        begin
            push_data.match_offset = off_ext[RESULT_OFF_W-1:0];
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        match_done_next = match_done_reg;
        if (region_end)
        begin
            byte_count_next = '0;
            match_done_next = 1'b0;
        end
        else
        begin
            if (step && counted)
            begin
                byte_count_next = count_inc;
            end
            if (hit_now)
            begin
                match_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            match_done_reg <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            match_done_reg <= match_done_next;
        end
    end

    // result queue: bytes keep flowing while a result waits
    wsm_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (head_data)
    );

    assign bytes.ready          = !fifo_full;
    assign results.found        = head_data.found;
    assign results.match_offset = head_data.match_offset;

endmodule

`default_nettype wire

// ===== sv/wsm_checker.sv =====
// Port-level checks on the wildcard byte signature matcher, bound to the top level.
`default_nettype none

module wsm_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        found,
    input  wire logic [31:0] match_offset
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
        else $error("result changed while stalled");

    // a not-found result carries offset zero
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == 32'd0)
        else $error("not-found result with nonzero offset");

    // a result only follows an accepted item
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted item");

    // with the result channel free, the byte channel never stalls
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("byte channel stalled with empty result queue");

endmodule

bind wildcard_byte_signature_match wsm_checker u_wsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (bytes.valid),
    .in_ready     (bytes.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .found        (results.found),
    .match_offset (results.match_offset)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the wildcard byte signature matcher.
`timescale 1ns / 100ps

module tb
    import wsm_pkg::*;
();

    localparam int MAX_LEN        = MAX_PATTERN_LEN_DEF;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int PRESSURE_PHASE = 5;
    localparam int CALM_FROM      = 10;    // phases from here on run without idling
    localparam int HOLD_CYCLES    = 300;   // long result back-pressure, once
    localparam int DRAIN_CYCLES   = 8;     // slack for the result queue to drain after the last awaited result
    localparam int QUIET_LIMIT    = 3000;  // cycles with no item moving on either channel
    localparam int NUM_ROWS       = 17;

    typedef enum logic [1:0] {
        ROW_PREDICT,    // expectation comes from the search model
        ROW_QUIET,      // byte must not produce a result
        ROW_REPORT      // byte produces the result typed in the row
    } row_kind_t;

    typedef struct packed {
        logic [1:0]  setup;     // 0 = registers as left by reset
        logic [7:0]  data;
        logic        last;
        row_kind_t   kind;
        logic        found;
        logic [31:0] offset;
    } row_t;

    typedef struct packed {
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [63:0] care;
        logic [63:0] len;
    } setup_t;

    // per-item tag handed from the stimulus to the scoreboard
    typedef struct packed {
        logic    typed;
        logic    has_report;
        result_t report;
    } search_note_t;

    // Directed setups: 1 = DE ?? BE EF with byte 1 wildcard, 2 = single cared byte 0x80.
    localparam setup_t DIRECTED_SETUPS [0:2] = '{
        '{64'h0, 64'h0, 64'h0, 64'h0},
        '{64'h0000_0000_EFBE_ADDE, 64'h0, 64'h0000_0000_0000_FFFD, 64'd4},
        '{64'h0000_0000_0000_0080, '1, 64'h0000_0000_0000_0001, 64'd1}
    };

    localparam row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        // zero-length pattern after reset: hit at offset 0 on the first byte
        '{2'd0, 8'h00, 1'b0, ROW_REPORT,  1'b1, 32'd0},
        // region end after a hit: silent
        '{2'd0, 8'hFF, 1'b1, ROW_QUIET,   1'b0, 32'd0},
        // region shorter than the pattern: not found, no wrap
        '{2'd1, 8'hDE, 1'b0, ROW_QUIET,   1'b0, 32'd0},
        '{2'd1, 8'hAD, 1'b1, ROW_REPORT,  1'b0, 32'd0},
        // hit on the final byte: one result only
        '{2'd1, 8'hDE, 1'b0, ROW_QUIET,   1'b0, 32'd0},
        '{2'd1, 8'hAD, 1'b0, ROW_QUIET,   1'b0, 32'd0},
        '{2'd1, 8'hBE, 1'b0, ROW_QUIET,   1'b0, 32'd0},
        '{2'd1, 8'hEF, 1'b1, ROW_REPORT,  1'b1, 32'd0},
        // wildcard position takes any byte, hit at offset 1, tail ignored
        '{2'd1, 8'h00, 1'b0, ROW_PREDICT, 1'b0, 32'd0},
        '{2'd1, 8'hDE, 1'b0, ROW_PREDICT, 1'b0, 32'd0},
        '{2'd1, 8'h55, 1'b0, ROW_PREDICT, 1'b0, 32'd0},
        '{2'd1, 8'hBE, 1'b0, ROW_PREDICT, 1'b0, 32'd0},
        '{2'd1, 8'hEF, 1'b0, ROW_REPORT,  1'b1, 32'd1},
        '{2'd1, 8'h7F, 1'b1, ROW_QUIET,   1'b0, 32'd0},
        // one-byte pattern
        '{2'd2, 8'h01, 1'b0, ROW_PREDICT, 1'b0, 32'd0},
        '{2'd2, 8'h80, 1'b0, ROW_REPORT,  1'b1, 32'd1},
        '{2'd2, 8'h80, 1'b1, ROW_QUIET,   1'b0, 32'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    wsm_byte_if   byte_ch ();
    wsm_result_if res_ch ();

    wildcard_byte_signature_match u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Search model: register copy and region state.
    logic [63:0] cfg_pat_lo;
    logic [63:0] cfg_pat_hi;
    logic [15:0] cfg_care;
    logic [4:0]  cfg_len;
    logic [7:0]  recent_bytes [MAX_LEN];   // index MAX_LEN-1 is the newest byte
    logic [31:0] seen_count;
    logic        region_hit;

    search_note_t item_notes [$];
    result_t      awaited_reports [$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    int           idle_pct       = 0;
    bit           pressure_on    = 1'b0;

    function automatic int active_len();
        // lengths above the window saturate
        return (int'(cfg_len) > MAX_LEN) ? MAX_LEN : int'(cfg_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        logic [127:0] both;
        both = {cfg_pat_hi, cfg_pat_lo};
        return both[k*8 +: 8];
    endfunction

    task automatic clear_region();
        int i;
        for (i = 0; i < MAX_LEN; i++)
            recent_bytes[i] = 8'h00;
        seen_count = '0;
        region_hit = 1'b0;
    endtask

    // One byte through the search model; got says whether a result follows.
    task automatic search_step(input logic [7:0] d, input logic l,
                               output bit got, output result_t r);
        int i;
        int k;
        int len;
        bit hit;
        got = 1'b0;
        r   = '0;
        if (!region_hit)
        begin
            len = active_len();
            for (i = 0; i < MAX_LEN - 1; i++)
                recent_bytes[i] = recent_bytes[i + 1];
            recent_bytes[MAX_LEN - 1] = d;
            // a saturated counter stops testing start positions
            if (seen_count != '1)
            begin
                seen_count++;
                if (seen_count >= 32'(len))
                begin
                    hit = 1'b1;
                    for (k = 0; k < len; k++)
                        if (cfg_care[k] && recent_bytes[MAX_LEN - len + k] != pattern_byte(k))
                            hit = 1'b0;
                    if (hit)
                    begin
                        region_hit     = 1'b1;
                        got            = 1'b1;
                        r.found        = 1'b1;
                        r.match_offset = (len == 0) ? '0 : seen_count - 32'(len);
                    end
                end
            end
            if (l && !got)
                got = 1'b1;     // not found: found = 0, offset 0
        end
        if (l)
            clear_region();
    endtask

    // Scoreboard: byte acceptance first, so an expectation is in place before its result.
    always @(posedge clk)
    begin : scoreboard
        search_note_t note;
        result_t      want;
        bit           got;
        bit           moved;
        moved = 1'b0;
        if (byte_ch.valid && byte_ch.ready)
        begin
            moved = 1'b1;
            note  = '0;
            if (item_notes.size() != 0)
                note = item_notes.pop_front();
            search_step(byte_ch.data_byte, byte_ch.last_byte, got, want);
            if (note.typed)
            begin
                got  = note.has_report;
                want = note.report;
            end
            if (got)
                awaited_reports.push_back(want);
        end
        if (res_ch.valid && res_ch.ready)
        begin
            moved = 1'b1;
            if (awaited_reports.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result found=%0b offset=%0d",
                             $realtime, res_ch.found, res_ch.match_offset);
                mismatch_count++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (res_ch.found !== want.found || res_ch.match_offset !== want.match_offset)
                begin
                    if (mismatch_count < 10)
                        $display({"%0t: result mismatch: expected found=%0b offset=%0d,",
                                  " got found=%0b offset=%0d"},
                                 $realtime, want.found, want.match_offset,
                                 res_ch.found, res_ch.match_offset);
                    mismatch_count++;
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold once the pressure phase starts.
    initial
    begin : result_sink
        int  n;
        bit  hold_done;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_on && !hold_done)
            begin
                // sender keeps offering; the result slots fill and bytes stall
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Offer one byte, optionally after an idle burst; returns at the accepting edge.
    task automatic send_byte(input logic [7:0] d, input logic l);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= d;
        byte_ch.last_byte <= l;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    // Quiesce: stop offering, collect every awaited result, then let the pipe drain.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_setup(input setup_t s);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_LOW;
        cfg_data  <= s.pat_lo;
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data  <= s.pat_hi;
        @(posedge clk);
        cfg_index <= REG_CARE_MASK;
        cfg_data  <= s.care;
        @(posedge clk);
        cfg_index <= REG_PATTERN_LEN;
        cfg_data  <= s.len;
        @(posedge clk);
        cfg_we <= 1'b0;
        // registers keep only their own width
        cfg_pat_lo = s.pat_lo;
        cfg_pat_hi = s.pat_hi;
        cfg_care   = s.care[15:0];
        cfg_len    = s.len[4:0];
    endtask

    // First phases pin the extremes; the rest draw lengths and masks at random.
    // Bits above each register's width are random junk.
    function automatic setup_t pick_setup(input int p);
        setup_t s;
        int     r;
        s.pat_lo = {$urandom, $urandom};
        s.pat_hi = {$urandom, $urandom};
        s.care   = {$urandom, $urandom};
        s.len    = {$urandom, $urandom};
        case (p)
            0:
            begin
                s.care[15:0] = 16'hFFFF;
                s.len[4:0]   = 5'd31;
            end
            1:
            begin
                s.care[15:0] = 16'h0000;
                s.len[4:0]   = 5'd16;
            end
            2:
                s.len[4:0] = 5'd0;
            3:
            begin
                s.pat_lo     = '1;
                s.pat_hi     = '1;
                s.care[15:0] = 16'hFFFF;
                s.len[4:0]   = 5'd16;
            end
            4:
            begin
                s.pat_lo     = '0;
                s.pat_hi     = '0;
                s.care[15:0] = 16'hFFFF;
                s.len[4:0]   = 5'd1;
            end
            PRESSURE_PHASE:
            begin
                // every region hits on its first byte: one result per short region
                s.care[15:0] = 16'h0000;
                s.len[4:0]   = 5'd1;
            end
            default:
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    s.len[4:0] = 5'd0;
                else if (r < 20)
                    s.len[4:0] = 5'($urandom_range(17, 31));
                else
                    s.len[4:0] = 5'($urandom_range(1, 16));
                r = $urandom_range(0, 99);
                if (r < 15)
                    s.care[15:0] = 16'h0000;
                else if (r < 30)
                    s.care[15:0] = 16'hFFFF;
            end
        endcase
        return s;
    endfunction

    // One region: mostly a planted pattern in random bytes, some with one cared byte
    // broken, the rest plain noise (which also gives regions shorter than the pattern).
    task automatic send_region(input bit short_only, output int count);
        logic [7:0]   region [$];
        search_note_t note;
        int           len;
        int           rlen;
        int           pos;
        int           k;
        int           mode;
        int           victim;
        len  = active_len();
        mode = $urandom_range(0, 99);
        note = '0;
        if (short_only)
            rlen = $urandom_range(1, 3);
        else if ($urandom_range(0, 19) == 0)
            rlen = $urandom_range(40, 64);
        else
            rlen = $urandom_range(1, len + 12);
        if (mode < 85 && rlen < len)
            rlen = len + $urandom_range(0, 8);
        for (k = 0; k < rlen; k++)
            region.push_back(8'($urandom_range(0, 255)));
        if (mode < 85 && len > 0 && rlen >= len)
        begin
            pos = $urandom_range(0, rlen - len);
            for (k = 0; k < len; k++)
                if (cfg_care[k])
                    region[pos + k] = pattern_byte(k);
            if (mode >= 70)
            begin
                victim = $urandom_range(0, len - 1);
                if (cfg_care[victim])
                    region[pos + victim] ^= 8'($urandom_range(1, 255));
            end
        end
        for (k = 0; k < rlen; k++)
        begin
            item_notes.push_back(note);
            send_byte(region[k], k == rlen - 1);
        end
        count = rlen;
    endtask

    initial
    begin : stimulus
        search_note_t note;
        row_t         row;
        int           cur_setup;
        int           r;
        int           p;
        int           sent;
        int           n;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_PATTERN_LOW;
        cfg_data          <= '0;
        cfg_pat_lo = '0;
        cfg_pat_hi = '0;
        cfg_care   = '0;
        cfg_len    = '0;
        clear_region();
        repeat (3) @(posedge clk);

        // directed rows, first under the reset register values
        cur_setup = 0;
        idle_pct  = 10;
        for (r = 0; r < NUM_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (int'(row.setup) != cur_setup)
            begin
                settle();
                load_setup(DIRECTED_SETUPS[row.setup]);
                cur_setup = int'(row.setup);
            end
            note.typed              = (row.kind != ROW_PREDICT);
            note.has_report         = (row.kind == ROW_REPORT);
            note.report.found       = row.found;
            note.report.match_offset = row.offset;
            item_notes.push_back(note);
            send_byte(row.data, row.last);
        end

        // random phases, each with its own register setting
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            load_setup(pick_setup(p));
            if (p >= CALM_FROM || p == 3)
                idle_pct = 0;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 6;
                    1:       idle_pct = 15;
                    default: idle_pct = 30;
                endcase
            end
            if (p == PRESSURE_PHASE)
                pressure_on = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_region(p == PRESSURE_PHASE, n);
                sent += n;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
